[src/tws_pkg.sv]
// Shared types and constants for the timer wheel scheduler.
`default_nettype none
package tws_pkg;

  localparam int ID_W       = 32;
  localparam int NOW_W      = 48;
  localparam int TIMEOUT_W  = 32;
  localparam int PERIOD_W   = 31;
  localparam int TICK_W     = 16;
  localparam int WAIT_W     = 16;
  localparam int LIVE_W     = 5;
  localparam int ORDER_W    = 16;
  localparam int KIND_W     = 2;
  localparam int FIRE_DEPTH = 48;
  localparam int FIRE_PTR_W = 6;
  localparam int DIV_CNT_W  = 6;
  localparam int EL_W       = NOW_W + 2;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 56;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd100;

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [KIND_W-1:0] RES_FIRE = 2'd0;
  localparam logic [KIND_W-1:0] RES_ADD  = 2'd1;
  localparam logic [KIND_W-1:0] RES_REM  = 2'd2;
  localparam logic [KIND_W-1:0] RES_WAIT = 2'd3;

  localparam logic [1:0] DIV_ADD    = 2'd0;
  localparam logic [1:0] DIV_REFILE = 2'd1;
  localparam logic [1:0] DIV_WHEEL  = 2'd2;

  typedef struct packed {
    logic              take;
    logic              div_start;
    logic [1:0]        div_src;
    logic              add_write;
    logic              refile_write;
    logic              mask_load;
    logic              mask_rem;
    logic              scan_start;
    logic              scan_step;
    logic              scan_max;
    logic              rem_commit;
    logic              fire;
    logic              tick_init;
    logic              slot_load;
    logic              step;
    logic              res_set;
    logic [KIND_W-1:0] res_kind;
    logic              res_ok;
    logic              res_wait_t;
    logic              fifo_rd;
    logic              out_fire;
    logic              out_last;
  } tws_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              add_ok;
    logic              mask_any;
    logic              found;
    logic              div_done;
    logic              has_period;
    logic              scan_last;
    logic              el_lt_t;
    logic              step_more;
    logic              step_wrap;
    logic              fifo_empty;
    logic              out_free;
  } tws_status_t;

endpackage
`default_nettype wire

[src/timer_wheel_scheduler_core.sv]
// Top level of the single-level timing wheel scheduler.
// Holds up to CAPACITY timers filed in SLOTS wheel slots; tick_ms sets the slot width. Each
// input transfer is handled alone: an add waits on the bit-serial slot divider; a remove
// waits on the table scan, which reads one entry a cycle. A tick that is due visits up to
// SLOTS + 1 slots; per timer found in a slot it runs a table scan, and a divide when the
// timer repeats; the first slot and any slot after wheel time wraps also pay one divide.
// Results leave from the fire buffer once the work ends.
`default_nettype none
module timer_wheel_scheduler_core
  import tws_pkg::*;
#(
  parameter int SLOTS    = 60,
  parameter int CAPACITY = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [TICK_W-1:0]     cfg_wdata,   // tick_ms
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,     // timer_id, now_ms, timeout_ms, interval_ms
  input  wire logic [KIND_W-1:0]     s_tuser,     // kind
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,     // fired_id, ok, wait_ms, live_count
  output logic [KIND_W-1:0]          m_tuser,     // result_kind
  output logic                       m_tlast
);

  tws_cmd_t    cmd;
  tws_status_t status;

  tws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tws_datapath #(
    .SLOTS    (SLOTS),
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

[src/tws_slot_div.sv]
// Bit-serial divider that yields (dividend / divisor) mod SLOTS.
`default_nettype none
module tws_slot_div
  import tws_pkg::*;
#(
  parameter int SLOTS = 60
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [NOW_W-1:0]          dividend,
  input  wire logic [TICK_W-1:0]         divisor,
  output logic                           done,
  output logic [$clog2(SLOTS)-1:0]       slot
);

  localparam int SLOT_W = $clog2(SLOTS);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [NOW_W-1:0]     dvd;
  logic [TICK_W-1:0]    rem;
  logic [TICK_W-1:0]    dsr;
  logic [SLOT_W-1:0]    qm;

  logic [TICK_W:0]   r2;
  logic              ge;
  logic [TICK_W:0]   r_sub;
  logic [SLOT_W:0]   q2;
  logic [SLOT_W:0]   q_sub;

  always_comb begin
    r2    = {rem, dvd[NOW_W-1]};
    ge    = r2 >= {1'b0, dsr};
    r_sub = r2 - {1'b0, dsr};
    q2    = {qm, ge};
    q_sub = q2 - (SLOT_W+1)'(SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NOW_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      qm  <= '0;
    end else if (busy) begin
      dvd <= {dvd[NOW_W-2:0], 1'b0};
      rem <= ge ? r_sub[TICK_W-1:0] : r2[TICK_W-1:0];
      qm  <= (q2 >= (SLOT_W+1)'(SLOTS)) ? q_sub[SLOT_W-1:0] : q2[SLOT_W-1:0];
    end
  end

  assign slot = qm;

endmodule
`default_nettype wire

[src/tws_datapath.sv]
// Timer table, wheel time, entry scan, fire buffer and output register.
`default_nettype none
module tws_datapath
  import tws_pkg::*;
#(
  parameter int SLOTS    = 60,
  parameter int CAPACITY = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire tws_cmd_t              cmd,
  output tws_status_t                status,
  input  wire logic [KIND_W-1:0]     s_tuser,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [TICK_W-1:0]     cfg_wdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic [KIND_W-1:0]          m_tuser,
  output logic                       m_tlast
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 2);

  logic [TICK_W-1:0]    tick_ms;
  logic [TICK_W-1:0]    t_eff;

  logic [KIND_W-1:0]    in_kind;
  logic [ID_W-1:0]      in_id;
  logic [NOW_W-1:0]     in_now;
  logic [TIMEOUT_W-1:0] in_timeout;
  logic [PERIOD_W-1:0]  in_interval;

  logic [CAPACITY-1:0]  entry_valid;
  logic [ID_W-1:0]      entry_id     [CAPACITY];
  logic [PERIOD_W-1:0]  entry_period [CAPACITY];
  logic [SLOT_W-1:0]    entry_slot   [CAPACITY];
  logic [ORDER_W-1:0]   entry_order  [CAPACITY];

  logic [NOW_W-1:0]     wheel_time;
  logic [ORDER_W-1:0]   order_counter;
  logic [ORDER_W-1:0]   order_snap;
  logic [EL_W-1:0]      elapsed;
  logic [CNT_W-1:0]     count;
  logic [SLOT_W-1:0]    cur_slot;

  logic [CAPACITY-1:0]  mask;
  logic [IDX_W:0]       scan_idx;
  logic [IDX_W-1:0]     best_idx;
  logic [ORDER_W-1:0]   best_age;
  logic                 found;

  logic [ID_W-1:0]       fire_mem [FIRE_DEPTH];
  logic [FIRE_PTR_W-1:0] wr_ptr;
  logic [FIRE_PTR_W-1:0] rd_ptr;
  logic [ID_W-1:0]       rd_data;

  logic [KIND_W-1:0]    res_kind;
  logic                 res_ok;
  logic [WAIT_W-1:0]    res_wait;

  logic                 div_start;
  logic [NOW_W-1:0]     div_dividend;
  logic                 div_done;
  logic [SLOT_W-1:0]    div_slot;

  logic [IDX_W-1:0]     free_idx;
  logic                 free_any;
  logic [CAPACITY-1:0]  slot_hit;
  logic [CAPACITY-1:0]  id_hit;
  logic [IDX_W-1:0]     sidx;
  logic [ORDER_W-1:0]   scan_age;
  logic                 better;
  logic [EL_W-1:0]      t_ext;
  logic [EL_W-1:0]      wait_diff;
  logic [WAIT_W-1:0]    wait_sat;
  logic [EL_W-1:0]      el_new;
  logic [CNT_W-1:0]     count_new;
  logic [NOW_W:0]       wsum;
  logic                 more;
  logic [LIVE_W-1:0]    live;
  logic                 out_free;

  assign t_eff     = (tick_ms == '0) ? TICK_W'(1) : tick_ms;
  assign t_ext     = {{(EL_W-TICK_W){1'b0}}, t_eff};
  assign wait_diff = t_ext - elapsed;
  assign wait_sat  = (|wait_diff[EL_W-1:WAIT_W]) ? {WAIT_W{1'b1}} : wait_diff[WAIT_W-1:0];
  assign el_new    = elapsed - t_ext;
  assign count_new = count + 1'b1;
  assign wsum      = {1'b0, wheel_time} + {{(NOW_W+1-TICK_W){1'b0}}, t_eff};
  assign more      = !($signed(el_new) < $signed(t_ext)) && (count_new <= CNT_W'(SLOTS));
  assign sidx      = scan_idx[IDX_W-1:0];
  assign scan_age  = order_snap - entry_order[sidx];
  assign better    = !found || (cmd.scan_max ? (scan_age > best_age) : (scan_age < best_age));
  assign out_free  = !m_tvalid || m_tready;

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_idx = IDX_W'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      slot_hit[i] = entry_slot[i] == cur_slot;
      id_hit[i]   = entry_id[i] == in_id;
    end
  end

  always_comb begin
    live = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      live = live + LIVE_W'(entry_valid[i]);
    end
  end

  always_comb begin
    case (cmd.div_src)
      DIV_ADD:    div_dividend = in_now + {{(NOW_W-TIMEOUT_W){1'b0}}, in_timeout};
      DIV_REFILE: div_dividend = in_now + {{(NOW_W-PERIOD_W){1'b0}}, entry_period[best_idx]};
      default:    div_dividend = wheel_time;
    endcase
  end

  assign div_start = cmd.div_start;

  tws_slot_div #(
    .SLOTS(SLOTS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (t_eff),
    .done     (div_done),
    .slot     (div_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms <= TICK_RESET;
    end else if (cfg_we) begin
      tick_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      in_kind     <= s_tuser;
      in_id       <= s_tdata[31:0];
      in_now      <= s_tdata[79:32];
      in_timeout  <= s_tdata[111:80];
      in_interval <= s_tdata[142:112];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= '0;
      order_counter <= '0;
      wheel_time    <= '0;
    end else begin
      if (cmd.add_write) begin
        entry_valid[free_idx] <= 1'b1;
        order_counter         <= order_counter + 1'b1;
      end
      if (cmd.refile_write) begin
        order_counter <= order_counter + 1'b1;
      end
      if (cmd.rem_commit && found) begin
        entry_valid[best_idx] <= 1'b0;
      end
      if (cmd.fire && entry_period[best_idx] == '0) begin
        entry_valid[best_idx] <= 1'b0;
      end
      if (cmd.step) begin
        wheel_time <= (!more && !($signed(el_new) < $signed(t_ext))) ? in_now : wsum[NOW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_write) begin
      entry_id[free_idx]     <= in_id;
      entry_period[free_idx] <= in_interval;
      entry_slot[free_idx]   <= div_slot;
      entry_order[free_idx]  <= order_counter;
    end
    if (cmd.refile_write) begin
      entry_slot[best_idx]  <= div_slot;
      entry_order[best_idx] <= order_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_init) begin
      elapsed <= {2'b00, in_now} - {2'b00, wheel_time};
      count   <= '0;
    end else if (cmd.step) begin
      elapsed <= el_new;
      count   <= count_new;
    end
    if (cmd.slot_load) begin
      cur_slot <= div_slot;
    end else if (cmd.step) begin
      cur_slot <= (cur_slot == SLOT_W'(SLOTS - 1)) ? '0 : cur_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mask_load) begin
      mask       <= entry_valid & (cmd.mask_rem ? id_hit : slot_hit);
      order_snap <= order_counter;
    end else if (cmd.fire) begin
      mask[best_idx] <= 1'b0;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
      found    <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (mask[sidx] && better) begin
        best_idx <= sidx;
        best_age <= scan_age;
        found    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (cmd.take) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.fire && wr_ptr < FIRE_PTR_W'(FIRE_DEPTH)) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd.fifo_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire && wr_ptr < FIRE_PTR_W'(FIRE_DEPTH)) begin
      fire_mem[wr_ptr] <= entry_id[best_idx];
    end
    if (cmd.fifo_rd) begin
      rd_data <= fire_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_kind <= cmd.res_kind;
      res_ok   <= cmd.res_ok;
      res_wait <= (cmd.res_kind != RES_WAIT) ? '0 : (cmd.res_wait_t ? t_eff : wait_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_fire || cmd.out_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      m_tdata <= {2'b00, live, {WAIT_W{1'b0}}, 1'b0, rd_data};
      m_tuser <= RES_FIRE;
      m_tlast <= 1'b0;
    end else if (cmd.out_last) begin
      m_tdata <= {2'b00, live, res_wait, res_ok, {ID_W{1'b0}}};
      m_tuser <= res_kind;
      m_tlast <= 1'b1;
    end
  end

  always_comb begin
    status.kind       = in_kind;
    status.add_ok     = !in_timeout[TIMEOUT_W-1] && (in_timeout != '0) && free_any;
    status.mask_any   = |mask;
    status.found      = found;
    status.div_done   = div_done;
    status.has_period = entry_period[best_idx] != '0;
    status.scan_last  = scan_idx == (IDX_W+1)'(CAPACITY - 1);
    status.el_lt_t    = $signed(elapsed) < $signed(t_ext);
    status.step_more  = more;
    status.step_wrap  = wsum[NOW_W];
    status.fifo_empty = rd_ptr == wr_ptr;
    status.out_free   = out_free;
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= FIRE_PTR_W'(FIRE_DEPTH))
    else $error("fire buffer write pointer past depth");

  a_fifo_order: assert property (@(posedge clk) disable iff (rst)
    rd_ptr <= wr_ptr)
    else $error("fire buffer read ahead of write");

  a_fire_sel: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> (found && mask[best_idx] && entry_valid[best_idx]))
    else $error("fired entry not selected from visited slot");

endmodule
`default_nettype wire

[src/tws_ctrl.sv]
// Control state machine sequencing add, remove and tick work.
`default_nettype none
module tws_ctrl
  import tws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire tws_status_t status,
  output tws_cmd_t         cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DECODE   = 4'd1;
  localparam logic [3:0] ST_ADD_DIV  = 4'd2;
  localparam logic [3:0] ST_REM_DONE = 4'd3;
  localparam logic [3:0] ST_TICK_CHK = 4'd4;
  localparam logic [3:0] ST_WSTART   = 4'd5;
  localparam logic [3:0] ST_WDIV     = 4'd6;
  localparam logic [3:0] ST_VISIT    = 4'd7;
  localparam logic [3:0] ST_VSEL     = 4'd8;
  localparam logic [3:0] ST_SCAN     = 4'd9;
  localparam logic [3:0] ST_FIRE     = 4'd10;
  localparam logic [3:0] ST_RDIV     = 4'd11;
  localparam logic [3:0] ST_STEP     = 4'd12;
  localparam logic [3:0] ST_DRAIN    = 4'd13;
  localparam logic [3:0] ST_FLOAD    = 4'd14;
  localparam logic [3:0] ST_LAST     = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       scan_rem;
  logic       scan_rem_next;

  assign s_tready = state == ST_IDLE;

  always_comb begin
    state_next    = state;
    scan_rem_next = scan_rem;
    cmd           = '0;
    cmd.scan_max  = !scan_rem;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (status.kind)
          KIND_ADD: begin
            if (status.add_ok) begin
              cmd.div_start = 1'b1;
              cmd.div_src   = DIV_ADD;
              state_next    = ST_ADD_DIV;
            end else begin
              cmd.res_set  = 1'b1;
              cmd.res_kind = RES_ADD;
              state_next   = ST_DRAIN;
            end
          end
          KIND_REM: begin
            cmd.mask_load  = 1'b1;
            cmd.mask_rem   = 1'b1;
            cmd.scan_start = 1'b1;
            scan_rem_next  = 1'b1;
            state_next     = ST_SCAN;
          end
          KIND_TICK: begin
            cmd.tick_init = 1'b1;
            state_next    = ST_TICK_CHK;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_ADD_DIV: begin
        cmd.div_src = DIV_ADD;
        if (status.div_done) begin
          cmd.add_write = 1'b1;
          cmd.res_set   = 1'b1;
          cmd.res_kind  = RES_ADD;
          cmd.res_ok    = 1'b1;
          state_next    = ST_DRAIN;
        end
      end
      ST_REM_DONE: begin
        cmd.rem_commit = 1'b1;
        cmd.res_set    = 1'b1;
        cmd.res_kind   = RES_REM;
        cmd.res_ok     = status.found;
        state_next     = ST_DRAIN;
      end
      ST_TICK_CHK: begin
        if (status.el_lt_t) begin
          cmd.res_set  = 1'b1;
          cmd.res_kind = RES_WAIT;
          state_next   = ST_DRAIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DIV_WHEEL;
          state_next    = ST_WDIV;
        end
      end
      ST_WSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_WHEEL;
        state_next    = ST_WDIV;
      end
      ST_WDIV: begin
        cmd.div_src = DIV_WHEEL;
        if (status.div_done) begin
          cmd.slot_load = 1'b1;
          state_next    = ST_VISIT;
        end
      end
      ST_VISIT: begin
        cmd.mask_load = 1'b1;
        scan_rem_next = 1'b0;
        state_next    = ST_VSEL;
      end
      ST_VSEL: begin
        if (status.mask_any) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = scan_rem ? ST_REM_DONE : ST_FIRE;
        end
      end
      ST_FIRE: begin
        cmd.fire    = 1'b1;
        cmd.div_src = DIV_REFILE;
        if (status.has_period) begin
          cmd.div_start = 1'b1;
          state_next    = ST_RDIV;
        end else begin
          state_next = ST_VSEL;
        end
      end
      ST_RDIV: begin
        cmd.div_src = DIV_REFILE;
        if (status.div_done) begin
          cmd.refile_write = 1'b1;
          state_next       = ST_VSEL;
        end
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (status.step_more) begin
          state_next = status.step_wrap ? ST_WSTART : ST_VISIT;
        end else begin
          cmd.res_set    = 1'b1;
          cmd.res_kind   = RES_WAIT;
          cmd.res_wait_t = 1'b1;
          state_next     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.fifo_empty) begin
          state_next = ST_LAST;
        end else begin
          cmd.fifo_rd = 1'b1;
          state_next  = ST_FLOAD;
        end
      end
      ST_FLOAD: begin
        if (status.out_free) begin
          cmd.out_fire = 1'b1;
          state_next   = ST_DRAIN;
        end
      end
      ST_LAST: begin
        if (status.out_free) begin
          cmd.out_last = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_rem <= 1'b0;
    end else begin
      state    <= state_next;
      scan_rem <= scan_rem_next;
    end
  end

endmodule
`default_nettype wire

[tb/sv/tws_checker.sv]
// Checker for the timer wheel scheduler: predicts every result and compares it.
`timescale 1ns / 1ps
module tws_checker
  import tws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [TICK_W-1:0]     cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic [KIND_W-1:0]     m_tuser,
  input  logic                  m_tlast,
  output int                    fail_count,
  output int                    pending
);

  localparam int NSLOT = 60;
  localparam int NTIMER = 16;
  localparam int FIRE_MAX = 48;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic              ok;
    logic [WAIT_W-1:0] wait_ms;
    logic [LIVE_W-1:0] live;
    logic              last;
  } result_t;

  result_t expected_results[$];

  logic [TICK_W-1:0]   tick_ms;
  logic                t_valid  [NTIMER];
  logic [ID_W-1:0]     t_id     [NTIMER];
  logic [NOW_W-1:0]    t_expiry [NTIMER];
  logic [PERIOD_W-1:0] t_period [NTIMER];
  logic [5:0]          t_slot   [NTIMER];
  logic [ORDER_W-1:0]  t_order  [NTIMER];
  logic [NOW_W-1:0]    wheel_time;
  logic [ORDER_W-1:0]  order_ctr;

  assign pending = expected_results.size();

  function automatic longint unsigned slot_width();
    return (tick_ms == 0) ? 1 : longint'(tick_ms);
  endfunction

  function automatic logic [ORDER_W-1:0] age(int i);
    return order_ctr - t_order[i];
  endfunction

  task automatic file_timer(int i, logic [NOW_W-1:0] expiry);
    t_expiry[i] = expiry;
    t_slot[i] = 6'((longint'(expiry) / slot_width()) % NSLOT);
    t_order[i] = order_ctr;
    order_ctr = order_ctr + 1'b1;
  endtask

  task automatic add_result(ref result_t q[$], input logic [KIND_W-1:0] k,
                            input logic [ID_W-1:0] id, input logic ok,
                            input logic [WAIT_W-1:0] w);
    result_t r;
    r.kind = k;
    r.id = id;
    r.ok = ok;
    r.wait_ms = w;
    r.live = '0;
    r.last = 1'b0;
    q.insert(q.size(), r);
  endtask

  task automatic visit_slot(logic [5:0] s, logic [NOW_W-1:0] now, ref result_t q[$],
                            ref int fires);
    int list[$];
    int v;
    int b;
    for (int i = 0; i < NTIMER; i++)
      if (t_valid[i] && t_slot[i] == s) list.insert(list.size(), i);
    for (int a = 1; a < list.size(); a++) begin
      v = list[a];
      b = a;
      while (b > 0 && age(list[b-1]) < age(v)) begin
        list[b] = list[b-1];
        b--;
      end
      list[b] = v;
    end
    foreach (list[k]) begin
      if (fires < FIRE_MAX) begin
        add_result(q, RES_FIRE, t_id[list[k]], 1'b0, '0);
        fires++;
      end
      if (t_period[list[k]] != 0)
        file_timer(list[k], now + NOW_W'(t_period[list[k]]));
      else
        t_valid[list[k]] = 1'b0;
    end
  endtask

  task automatic predict(logic [KIND_W-1:0] kind, logic [IN_DATA_W-1:0] d);
    logic [ID_W-1:0]      id;
    logic [NOW_W-1:0]     now;
    logic [TIMEOUT_W-1:0] timeout;
    logic [PERIOD_W-1:0]  interval;
    result_t q[$];
    logic ok;
    int best;
    int fires;
    int visits;
    longint t;
    longint elapsed;
    longint w;
    int live;
    id       = d[31:0];
    now      = d[79:32];
    timeout  = d[111:80];
    interval = d[142:112];
    if (kind == KIND_ADD) begin
      ok = 1'b0;
      if (!timeout[31] && timeout != 0)
        for (int i = 0; i < NTIMER; i++)
          if (!ok && !t_valid[i]) begin
            t_valid[i] = 1'b1;
            t_id[i] = id;
            t_period[i] = interval;
            file_timer(i, now + NOW_W'(timeout));
            ok = 1'b1;
          end
      add_result(q, RES_ADD, '0, ok, '0);
    end else if (kind == KIND_REM) begin
      best = -1;
      for (int i = 0; i < NTIMER; i++)
        if (t_valid[i] && t_id[i] == id && (best < 0 || age(i) < age(best))) best = i;
      if (best >= 0) t_valid[best] = 1'b0;
      add_result(q, RES_REM, '0, best >= 0, '0);
    end else if (kind == KIND_TICK) begin
      t = longint'(slot_width());
      elapsed = longint'(now) - longint'(wheel_time);
      if (elapsed < t) begin
        w = t - elapsed;
        if (w > 65535) w = 65535;
        add_result(q, RES_WAIT, '0, 1'b0, WAIT_W'(w));
      end else begin
        visits = 0;
        fires = 0;
        while (elapsed >= t) begin
          visit_slot(6'((longint'(wheel_time) / t) % NSLOT), now, q, fires);
          wheel_time = wheel_time + NOW_W'(t);
          elapsed -= t;
          visits++;
          if (visits > NSLOT) break;
        end
        if (elapsed >= t) wheel_time = now;
        add_result(q, RES_WAIT, '0, 1'b0, WAIT_W'(t));
      end
    end else begin
      return;
    end
    live = 0;
    for (int i = 0; i < NTIMER; i++) live += t_valid[i];
    foreach (q[k]) begin
      q[k].live = LIVE_W'(live);
      q[k].last = (k == q.size() - 1);
      expected_results.insert(expected_results.size(), q[k]);
    end
  endtask

  task automatic check_result();
    result_t e;
    if (expected_results.size() == 0) begin
      $error("unexpected result transfer: kind %0d data %h", m_tuser, m_tdata);
      fail_count++;
      return;
    end
    e = expected_results.pop_front();
    if (m_tuser != e.kind) begin
      $error("result_kind exp %0d got %0d", e.kind, m_tuser); fail_count++;
    end
    if (m_tdata[31:0] != e.id) begin
      $error("fired_id exp %0d got %0d", e.id, m_tdata[31:0]); fail_count++;
    end
    if (m_tdata[32] != e.ok) begin
      $error("ok exp %0d got %0d", e.ok, m_tdata[32]); fail_count++;
    end
    if (m_tdata[48:33] != e.wait_ms) begin
      $error("wait_ms exp %0d got %0d", e.wait_ms, m_tdata[48:33]); fail_count++;
    end
    if (m_tdata[53:49] != e.live) begin
      $error("live_count exp %0d got %0d", e.live, m_tdata[53:49]); fail_count++;
    end
    if (m_tlast != e.last) begin
      $error("last exp %0d got %0d", e.last, m_tlast); fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tick_ms = TICK_RESET;
      for (int i = 0; i < NTIMER; i++) t_valid[i] = 1'b0;
      wheel_time = '0;
      order_ctr = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) tick_ms = cfg_wdata;
      if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
  end

endmodule

[tb/sv/tb_timer_wheel_scheduler_core.sv]
// Testbench top: drives stimulus into the timer wheel scheduler and reports the verdict.
`timescale 1ns / 1ps
module tb_timer_wheel_scheduler_core;
  import tws_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int HOLD_CYCLES = 5000;
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [TICK_W-1:0]     cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;
  int                    fail_count;
  int                    pending;
  logic                  hold_go = 1'b0;
  logic [NOW_W-1:0]      clock_ms = '0;
  logic [TICK_W-1:0]     cur_tick = TICK_RESET;
  int                    idle_cycles = 0;

  always #10 clk = ~clk;

  timer_wheel_scheduler_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  tws_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .fail_count(fail_count), .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id, logic [NOW_W-1:0] now,
                      logic [TIMEOUT_W-1:0] timeout, logic [PERIOD_W-1:0] interval);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {1'b0, interval, timeout, now, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_tick(logic [TICK_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    cur_tick = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [ID_W-1:0] id;
    logic [TIMEOUT_W-1:0] timeout;
    logic [PERIOD_W-1:0] interval;
    logic [NOW_W-1:0] now;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 7);
    if (r < 40) begin
      case ($urandom_range(0, 9))
        0: timeout = $urandom;
        1: timeout = 0;
        default: timeout = $urandom_range(1, 40 * cur_tick);
      endcase
      case ($urandom_range(0, 9))
        0: interval = PERIOD_W'($urandom);
        1, 2, 3, 4: interval = 0;
        default: interval = PERIOD_W'($urandom_range(1, 20 * cur_tick));
      endcase
      send(KIND_ADD, id, clock_ms, timeout, interval);
    end else if (r < 60) begin
      send(KIND_REM, id, clock_ms, $urandom, PERIOD_W'($urandom));
    end else if (r < 97) begin
      case ($urandom_range(0, 19))
        0: now = clock_ms - $urandom_range(0, 3 * cur_tick);
        1: now = clock_ms + 70 * cur_tick;
        2: now = NOW_W'({$urandom, $urandom});
        default: now = clock_ms + $urandom_range(0, 3 * cur_tick);
      endcase
      clock_ms = now;
      send(KIND_TICK, $urandom, now, $urandom, PERIOD_W'($urandom));
    end else begin
      send(KIND_IGNORED, $urandom, NOW_W'({$urandom, $urandom}), $urandom, '0);
    end
  endtask

  task automatic random_phase(int count);
    repeat (count) random_item();
  endtask

  initial begin
    int seq;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_go = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) seq = 1; else seq = $urandom_range(5, 40);
      m_tready <= 1'b1;
      repeat (seq) @(posedge clk);
      m_tready <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(KIND_ADD, 32'd1, 48'd0, 32'd0, 31'd0);
    send(KIND_ADD, 32'd1, 48'd0, 32'h8000_0000, 31'd0);
    send(KIND_ADD, 32'd1, 48'd0, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send(KIND_ADD, 32'hFFFF_FFFF, 48'd0, 32'd150, 31'd0);
    send(KIND_ADD, 32'd5, 48'd10, 32'd150, 31'd300);
    send(KIND_ADD, 32'd5, 48'd20, 32'd90, 31'd0);
    send(KIND_REM, 32'd5, 48'd0, 32'd0, 31'd0);
    send(KIND_REM, 32'd77, 48'd0, 32'd0, 31'd0);
    send(KIND_TICK, 32'd0, 48'd50, 32'd0, 31'd0);
    send(KIND_IGNORED, 32'd9, 48'd1000, 32'd5, 31'd0);
    for (int i = 0; i < 14; i++)
      send(KIND_ADD, 32'(i + 10), 48'd0, 32'(100 * i + 1), 31'(i % 3 * 200));
    send(KIND_TICK, 32'd0, 48'd250, 32'd0, 31'd0);
    send(KIND_TICK, 32'd0, 48'd100, 32'd0, 31'd0);
    send(KIND_TICK, 32'd0, 48'hFFFF_FFFF_FFFF, 32'd0, 31'd0);
    clock_ms = 48'hFFFF_FFFF_FFFF;
    random_phase(60);
    set_tick(16'd1);
    hold_go = 1'b1;
    random_phase(120);
    set_tick(16'd65535);
    clock_ms = 48'hFFFF_FF00_0000;
    random_phase(100);
    set_tick(16'($urandom_range(2, 999)));
    random_phase(120);
    set_tick(TICK_RESET);
    random_phase(100);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
src/tws_pkg.sv
src/tws_slot_div.sv
src/tws_datapath.sv
src/tws_ctrl.sv
src/timer_wheel_scheduler_core.sv
tb/sv/tws_checker.sv
tb/sv/tb_timer_wheel_scheduler_core.sv
